// ===== hdl/sv39ptw_pkg.sv =====
package sv39ptw_pkg;

   localparam int TABLE_PAGES_DEFAULT = 8;
   localparam int ENTRIES_PER_PAGE    = 512;

   localparam int VPN_W      = 9;
   localparam int PAGE_SHIFT = 12;
   localparam int PPN_LSB    = 10;
   localparam int PPN_W      = 44;
   localparam int PA_W       = 56;
   localparam int VA_W       = 39;
   localparam int EADDR_W    = 12;
   localparam int ENTRY_W    = 64;
   localparam int LEVEL_W    = 2;

   // stream payload widths, padded to whole bytes; csr index, csr data and root page widths
   localparam int REQ_DATA_W  = 120;
   localparam int RSP_DATA_W  = 64;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 44;
   localparam int ROOT_PAGE_W = 3;

   localparam logic OP_TRANSLATE = 1'b0;
   localparam logic OP_WRITE     = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_REGION_BASE = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROOT_PAGE   = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROOT_ENABLE = 2'd2;

   // entry flag bits
   localparam int BIT_V = 0;
   localparam int BIT_R = 1;
   localparam int BIT_X = 3;

   // microprogram addresses
   localparam int UPC_W = 3;
   localparam logic [UPC_W-1:0] UPC_CLEAR    = 3'd0;
   localparam logic [UPC_W-1:0] UPC_WAIT     = 3'd1;
   localparam logic [UPC_W-1:0] UPC_DISPATCH = 3'd2;
   localparam logic [UPC_W-1:0] UPC_ROOT     = 3'd3;
   localparam logic [UPC_W-1:0] UPC_WALK     = 3'd4;
   localparam logic [UPC_W-1:0] UPC_WALK_OUT = 3'd5;
   localparam logic [UPC_W-1:0] UPC_WRITE    = 3'd6;
   localparam logic [UPC_W-1:0] UPC_FAULT    = 3'd7;

   typedef enum logic [2:0] {
      COND_NONE       = 3'd0,
      COND_NO_ACCEPT  = 3'd1,
      COND_IS_WRITE   = 3'd2,
      COND_ROOT_BAD   = 3'd3,
      COND_DESCEND    = 3'd4,
      COND_OUT_BUSY   = 3'd5,
      COND_CLEAR_MORE = 3'd6
   } cond_type;

   typedef enum logic [1:0] {
      RES_NONE  = 2'd0,
      RES_WALK  = 2'd1,
      RES_WRITE = 2'd2,
      RES_FAULT = 2'd3
   } res_sel_type;

   typedef struct packed {
      logic        accept;
      logic        clear;
      logic        root_read;
      logic        walk;
      logic        write_entry;
      res_sel_type res_sel;
   } ctl_type;

   typedef struct packed {
      ctl_type           ctl;
      cond_type          cond;
      logic              done;
      logic [UPC_W-1:0]  target;
   } uword_type;

   typedef struct packed {
      logic req_fire;
      logic is_write;
      logic root_bad;
      logic descend;
      logic out_busy;
      logic clear_more;
   } status_type;

   typedef struct packed {
      logic [PPN_W-1:0]       region_base_ppn;
      logic [ROOT_PAGE_W-1:0] root_page;
      logic                   root_enable;
   } cfg_type;

   // control store: a taken jump goes to target, otherwise to the next step
   // or, with done set, back to the wait step
   function automatic uword_type ucode_word(input logic [UPC_W-1:0] upc);
      uword_type w;
      w = '0;
      w.ctl.res_sel = RES_NONE;
      w.cond = COND_NONE;
      unique case (upc)
         UPC_CLEAR: begin
            w.ctl.clear = 1'b1;
            w.cond      = COND_CLEAR_MORE;
            w.target    = UPC_CLEAR;
         end
         UPC_WAIT: begin
            w.ctl.accept = 1'b1;
            w.cond       = COND_NO_ACCEPT;
            w.target     = UPC_WAIT;
         end
         UPC_DISPATCH: begin
            w.cond   = COND_IS_WRITE;
            w.target = UPC_WRITE;
         end
         UPC_ROOT: begin
            w.ctl.root_read = 1'b1;
            w.cond          = COND_ROOT_BAD;
            w.target        = UPC_FAULT;
         end
         UPC_WALK: begin
            w.ctl.walk = 1'b1;
            w.cond     = COND_DESCEND;
            w.target   = UPC_WALK;
         end
         UPC_WALK_OUT: begin
            w.ctl.res_sel = RES_WALK;
            w.cond        = COND_OUT_BUSY;
            w.target      = UPC_WALK_OUT;
            w.done        = 1'b1;
         end
         UPC_WRITE: begin
            w.ctl.write_entry = 1'b1;
            w.ctl.res_sel     = RES_WRITE;
            w.cond            = COND_OUT_BUSY;
            w.target          = UPC_WRITE;
            w.done            = 1'b1;
         end
         UPC_FAULT: begin
            w.ctl.res_sel = RES_FAULT;
            w.cond        = COND_OUT_BUSY;
            w.target      = UPC_FAULT;
            w.done        = 1'b1;
         end
      endcase
      return w;
   endfunction

   function automatic logic [VPN_W-1:0] vpn_of(input logic [VA_W-1:0] va,
                                               input logic [LEVEL_W-1:0] level);
      logic [VPN_W-1:0] v;
      case (level)
         2'd2:    v = va[PAGE_SHIFT + 2*VPN_W +: VPN_W];
         2'd1:    v = va[PAGE_SHIFT + VPN_W +: VPN_W];
         default: v = va[PAGE_SHIFT +: VPN_W];
      endcase
      return v;
   endfunction

endpackage

// ===== hdl/sv39ptw_ram.sv =====
module sv39ptw_ram
   import sv39ptw_pkg::*;
#(
   parameter int WIDTH = ENTRY_W,
   parameter int DEPTH = TABLE_PAGES_DEFAULT * ENTRIES_PER_PAGE,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         store_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= store_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/sv39ptw_seq.sv =====
module sv39ptw_seq
   import sv39ptw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   output ctl_type    ctl
);

   logic [UPC_W-1:0] upc_ff, upc_in;
   uword_type        uw;
   logic             jump;

   always_comb begin
      uw = ucode_word(upc_ff);
      unique case (uw.cond)
         COND_NONE:       jump = 1'b0;
         COND_NO_ACCEPT:  jump = !status.req_fire;
         COND_IS_WRITE:   jump = status.is_write;
         COND_ROOT_BAD:   jump = status.root_bad;
         COND_DESCEND:    jump = status.descend;
         COND_OUT_BUSY:   jump = status.out_busy;
         COND_CLEAR_MORE: jump = status.clear_more;
         default:         jump = 1'b0;
      endcase
      if (jump) begin
         upc_in = uw.target;
      end else if (uw.done) begin
         upc_in = UPC_WAIT;
      end else begin
         upc_in = upc_ff + UPC_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= UPC_CLEAR;
      end else begin
         upc_ff <= upc_in;
      end
   end

   assign ctl = uw.ctl;

endmodule

// ===== hdl/sv39ptw_dp.sv =====
module sv39ptw_dp
   import sv39ptw_pkg::*;
#(
   parameter int TABLE_PAGES = TABLE_PAGES_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ctl_type               ctl,
   input  cfg_type               cfg,
   output status_type            status,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser
);

   localparam int STORE_WORDS = TABLE_PAGES * ENTRIES_PER_PAGE;
   localparam int PAGE_W      = (TABLE_PAGES > 1) ? $clog2(TABLE_PAGES) : 1;
   localparam int ADDR_W      = $clog2(STORE_WORDS);
   // one spare bit so the store size itself fits in the range compare
   localparam int WIDE_W      = ((ADDR_W > EADDR_W) ? ADDR_W : EADDR_W) + 1;
   localparam int ROOT_CMP_W  = 8;
   localparam int RSP_PAD_W   = RSP_DATA_W - PA_W - 1 - LEVEL_W;

   logic                  op_ff, op_in;
   logic [VA_W-1:0]       va_ff, va_in;
   logic [EADDR_W-1:0]    eaddr_ff, eaddr_in;
   logic [ENTRY_W-1:0]    evalue_ff, evalue_in;
   logic [LEVEL_W-1:0]    level_ff, level_in;
   logic [ADDR_W-1:0]     clr_ff, clr_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_user_ff, rsp_user_in;

   logic                  ram_we, ram_re;
   logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
   logic [ENTRY_W-1:0]    ram_wdata, ram_rdata;

   logic [PPN_W-1:0]      ppn, rel;
   logic                  ent_valid, ent_leaf, ptr_ok, hit, load;
   logic [PA_W-1:0]       offset, walk_pa, res_pa;
   logic                  res_hit, res_wdone;
   logic [LEVEL_W-1:0]    res_level, next_level;
   logic [PAGE_W-1:0]     root_idx, next_page;
   logic [WIDE_W-1:0]     wr_wide;
   logic                  wr_in_range;

   sv39ptw_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (STORE_WORDS)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // entry decode on the store's read register
   assign ppn        = ram_rdata[PPN_LSB +: PPN_W];
   assign rel        = ppn - cfg.region_base_ppn;
   assign ent_valid  = ram_rdata[BIT_V];
   assign ent_leaf   = |ram_rdata[BIT_X:BIT_R];
   assign ptr_ok     = (ppn >= cfg.region_base_ppn) && (rel < PPN_W'(TABLE_PAGES));
   assign hit        = ent_valid && ent_leaf;
   assign next_level = level_ff - LEVEL_W'(1);
   assign next_page  = rel[PAGE_W-1:0];
   assign root_idx   = PAGE_W'(cfg.root_page);

   assign req_tready        = ctl.accept;
   assign status.req_fire   = req_tvalid && ctl.accept;
   assign status.is_write   = (op_ff == OP_WRITE);
   assign status.root_bad   = !cfg.root_enable ||
                              (ROOT_CMP_W'(cfg.root_page) >= ROOT_CMP_W'(TABLE_PAGES));
   assign status.descend    = ent_valid && !ent_leaf && (level_ff != '0) && ptr_ok;
   assign status.out_busy   = rsp_valid_ff && !rsp_tready;
   assign status.clear_more = (clr_ff != ADDR_W'(STORE_WORDS - 1));

   // next read goes out in the same cycle the current entry is checked
   assign ram_re    = (ctl.root_read && !status.root_bad) || (ctl.walk && status.descend);
   assign ram_raddr = ctl.root_read ? ADDR_W'({root_idx, vpn_of(va_ff, 2'd2)})
                                    : ADDR_W'({next_page, vpn_of(va_ff, next_level)});

   assign wr_wide     = WIDE_W'(eaddr_ff);
   assign wr_in_range = (wr_wide < WIDE_W'(STORE_WORDS));
   assign ram_we      = ctl.clear || (ctl.write_entry && wr_in_range && !status.out_busy);
   assign ram_waddr   = ctl.clear ? clr_ff : wr_wide[ADDR_W-1:0];
   assign ram_wdata   = ctl.clear ? '0 : evalue_ff;

   always_comb begin
      case (level_ff)
         2'd2:    offset = PA_W'(va_ff[PAGE_SHIFT + 2*VPN_W - 1:0]);
         2'd1:    offset = PA_W'(va_ff[PAGE_SHIFT + VPN_W - 1:0]);
         default: offset = PA_W'(va_ff[PAGE_SHIFT - 1:0]);
      endcase
      walk_pa = (PA_W'(ppn) << PAGE_SHIFT) + offset;
   end

   always_comb begin
      res_pa    = '0;
      res_hit   = 1'b0;
      res_level = '0;
      res_wdone = 1'b0;
      unique case (ctl.res_sel) inside
         RES_WALK: begin
            if (hit) begin
               res_pa    = walk_pa;
               res_hit   = 1'b1;
               res_level = level_ff;
            end
         end
         RES_WRITE: res_wdone = 1'b1;
         RES_FAULT, RES_NONE: begin
         end
         default: begin
         end
      endcase
   end

   assign load = (ctl.res_sel != RES_NONE) && !status.out_busy;

   always_comb begin
      op_in     = op_ff;
      va_in     = va_ff;
      eaddr_in  = eaddr_ff;
      evalue_in = evalue_ff;
      if (status.req_fire) begin
         op_in     = req_tuser;
         va_in     = req_tdata[VA_W-1:0];
         eaddr_in  = req_tdata[VA_W +: EADDR_W];
         evalue_in = req_tdata[VA_W + EADDR_W +: ENTRY_W];
      end

      level_in = level_ff;
      if (ctl.root_read) begin
         level_in = 2'd2;
      end else if (ctl.walk && status.descend) begin
         level_in = next_level;
      end

      clr_in = ctl.clear ? clr_ff + ADDR_W'(1) : clr_ff;

      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (load) begin
         rsp_data_in  = {{RSP_PAD_W{1'b0}}, res_level, res_hit, res_pa};
         rsp_user_in  = res_wdone;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      va_ff       <= va_in;
      eaddr_ff    <= eaddr_in;
      evalue_ff   <= evalue_in;
      level_ff    <= level_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ===== hdl/sv39_page_table_walker_top.sv =====
// Sv39 page-table walker over a local store of TABLE_PAGES table pages.
// req channel: tuser = op (translate or entry write); tdata carries va,
// entry_address and entry_value. Each item gives exactly one rsp transfer:
// tdata carries pa, hit and leaf_level; tuser flags a write acknowledge.
// csr channel: csr_index selects region base PPN, root page or root enable;
// always ready; the user must write it only while no item is in flight, a rule the block leaves to the user.
// Items are handled one at a time by a microprogram sequencer; the store
// has one read port, so each table level costs one dependent read.
// Steps per item after accept: entry write dispatch, write; root fault
//   dispatch, root, fault; walk dispatch, root, one walk step per level read, output.
// The result lands in an output register; req_tready returns while it
// waits. If rsp_tready stays low, the next item stalls in its final step
// until the register frees.
// After reset the store is cleared, one entry per cycle, all
// TABLE_PAGES*512 entries (4096 by default); req_tready stays low meanwhile,
// csr writes are taken. Configuration registers reset to zero.
module sv39_page_table_walker_top
   import sv39ptw_pkg::*;
#(
   parameter int TABLE_PAGES = TABLE_PAGES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,  // va[38:0], entry_address[50:39], entry_value[114:51]
   input  logic                   req_tuser,  // op
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_DATA_W-1:0]  rsp_tdata,  // pa[55:0], hit[56], leaf_level[58:57]
   output logic                   rsp_tuser,  // write_done
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic [PPN_W-1:0]       region_ff, region_in;
   logic [ROOT_PAGE_W-1:0] root_page_ff, root_page_in;
   logic                   root_en_ff, root_en_in;
   cfg_type                cfg;
   ctl_type                ctl;
   status_type             status;

   assign csr_ready = 1'b1;

   always_comb begin
      region_in    = region_ff;
      root_page_in = root_page_ff;
      root_en_in   = root_en_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_REGION_BASE: region_in    = csr_data[PPN_W-1:0];
            CSR_ROOT_PAGE:   root_page_in = csr_data[ROOT_PAGE_W-1:0];
            CSR_ROOT_ENABLE: root_en_in   = csr_data[0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         region_ff    <= '0;
         root_page_ff <= '0;
         root_en_ff   <= 1'b0;
      end else begin
         region_ff    <= region_in;
         root_page_ff <= root_page_in;
         root_en_ff   <= root_en_in;
      end
   end

   assign cfg.region_base_ppn = region_ff;
   assign cfg.root_page       = root_page_ff;
   assign cfg.root_enable     = root_en_ff;

   sv39ptw_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctl    (ctl)
   );

   sv39ptw_dp #(
      .TABLE_PAGES (TABLE_PAGES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .cfg        (cfg),
      .status     (status),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // one item at a time: no transfer right after a transfer
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("req accepted while previous item in flight");

   // a result is produced from a busy step, never from the wait step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result appeared without an item in flight");

   // store clear runs after reset before any item is taken
   assert property (@(posedge clock)
      $past(reset) |-> !req_tready)
      else $error("req ready during store clear");

endmodule

// ===== test/sv39_walk_checker.sv =====
module sv39_walk_checker
   import sv39ptw_pkg::*;
#(
   parameter int TABLE_PAGES = TABLE_PAGES_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic                   req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   rsp_tuser,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data,
   output int                     results_owed,
   output int                     mismatches
);

   localparam int STORE_WORDS = TABLE_PAGES * ENTRIES_PER_PAGE;

   typedef struct packed {
      logic [PA_W-1:0]    pa;
      logic               hit;
      logic [LEVEL_W-1:0] leaf_level;
      logic               write_done;
   } xlat_type;

   logic [ENTRY_W-1:0] shadow_tables [STORE_WORDS];
   cfg_type            shadow_cfg;
   xlat_type           owed_xlats [$];
   int                 n_bad = 0;

   // walk the shadow tables from the root down; any fault leaves the result zero
   function automatic xlat_type walk_tables(input logic [VA_W-1:0] va);
      xlat_type           r;
      logic [PPN_W-1:0]   page;
      logic [PPN_W-1:0]   ppn;
      logic [PPN_W-1:0]   rel;
      logic [ENTRY_W-1:0] pte;
      logic [PA_W-1:0]    offset_mask;
      int unsigned        word;
      r = '0;
      if (!shadow_cfg.root_enable || shadow_cfg.root_page >= TABLE_PAGES)
         return r;
      page = PPN_W'(shadow_cfg.root_page);
      for (int lvl = 2; lvl >= 0; lvl--) begin
         word = 32'(page) * ENTRIES_PER_PAGE + 32'(va[PAGE_SHIFT + VPN_W*lvl +: VPN_W]);
         pte  = shadow_tables[word % STORE_WORDS];
         ppn  = pte[PPN_LSB +: PPN_W];
         if (!pte[BIT_V])
            return r;
         if (pte[BIT_X:BIT_R] != '0) begin
            offset_mask  = (PA_W'(1) << (PAGE_SHIFT + VPN_W*lvl)) - PA_W'(1);
            r.pa         = {ppn, {PAGE_SHIFT{1'b0}}} + (PA_W'(va) & offset_mask);
            r.hit        = 1'b1;
            r.leaf_level = LEVEL_W'(lvl);
            return r;
         end
         if (lvl == 0)
            return r;
         rel = ppn - shadow_cfg.region_base_ppn;
         if (ppn < shadow_cfg.region_base_ppn || rel >= PPN_W'(TABLE_PAGES))
            return r;
         page = rel;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      xlat_type           got;
      xlat_type           want;
      logic [EADDR_W-1:0] eaddr;
      if (reset) begin
         for (int i = 0; i < STORE_WORDS; i++)
            shadow_tables[i] = '0;
         shadow_cfg = '0;
         owed_xlats.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_REGION_BASE: shadow_cfg.region_base_ppn = csr_data[PPN_W-1:0];
               CSR_ROOT_PAGE:   shadow_cfg.root_page       = csr_data[ROOT_PAGE_W-1:0];
               CSR_ROOT_ENABLE: shadow_cfg.root_enable     = csr_data[0];
               default: ;
            endcase
         end
         // results first: one taken now belongs to an earlier request
         if (rsp_tvalid && rsp_tready) begin
            got.pa         = rsp_tdata[PA_W-1:0];
            got.hit        = rsp_tdata[PA_W];
            got.leaf_level = rsp_tdata[PA_W+1 +: LEVEL_W];
            got.write_done = rsp_tuser;
            if (owed_xlats.size() == 0) begin
               $display("%0t: unexpected result transfer: expected none, actual %h",
                        $time, got);
               n_bad++;
            end else begin
               want = owed_xlats.pop_front();
               if (got.pa !== want.pa) begin
                  $display("%0t: pa expected %h actual %h", $time, want.pa, got.pa);
                  n_bad++;
               end
               if (got.hit !== want.hit) begin
                  $display("%0t: hit expected %b actual %b", $time, want.hit, got.hit);
                  n_bad++;
               end
               if (got.leaf_level !== want.leaf_level) begin
                  $display("%0t: leaf_level expected %0d actual %0d", $time,
                           want.leaf_level, got.leaf_level);
                  n_bad++;
               end
               if (got.write_done !== want.write_done) begin
                  $display("%0t: write_done expected %b actual %b", $time,
                           want.write_done, got.write_done);
                  n_bad++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser == OP_WRITE) begin
               eaddr = req_tdata[VA_W +: EADDR_W];
               if (eaddr < STORE_WORDS)
                  shadow_tables[eaddr] = req_tdata[VA_W+EADDR_W +: ENTRY_W];
               want            = '0;
               want.write_done = 1'b1;
            end else begin
               want = walk_tables(req_tdata[VA_W-1:0]);
            end
            owed_xlats.push_back(want);
         end
      end
      results_owed <= owed_xlats.size();
      mismatches   <= n_bad;
   end

endmodule

// ===== test/tb_sv39_page_table_walker_top.sv =====
module tb_sv39_page_table_walker_top
   import sv39ptw_pkg::*;
();

   localparam int PAGES = TABLE_PAGES_DEFAULT;

   // low nibble of an entry: X W R V
   localparam logic [3:0] PTE_PTR     = 4'b0001;
   localparam logic [3:0] PTE_RV      = 4'b0011;
   localparam logic [3:0] PTE_XV      = 4'b1001;
   localparam logic [3:0] PTE_XWV     = 4'b1101;
   localparam logic [3:0] PTE_RWX_NOV = 4'b1110;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   int results_owed;
   int mismatches;

   sv39_page_table_walker_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   sv39_walk_checker #(.TABLE_PAGES(PAGES)) walk_check (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .results_owed (results_owed),
      .mismatches   (mismatches)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // result side: stall style changes every so often
   int unsigned stall_mode = 0;
   int unsigned stall_left = 0;

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(20, 200);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= 1'($urandom_range(0, 1));
         2:       rsp_tready <= (stall_left % 16 == 0);
         default: rsp_tready <= ($urandom_range(0, 7) != 0);
      endcase
   end

   int unsigned      burst_left = 0;
   int unsigned      items_sent = 0;
   logic [PPN_W-1:0] cfg_base   = '0;
   logic [2:0]       cfg_root   = '0;

   task automatic send_item(input logic op, input logic [VA_W-1:0] va,
                            input logic [EADDR_W-1:0] eaddr,
                            input logic [ENTRY_W-1:0] pte);
      int unsigned gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      end
      burst_left--;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{(REQ_DATA_W-VA_W-EADDR_W-ENTRY_W){1'b0}}, pte, eaddr, va};
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic write_pte(input logic [2:0] page, input logic [VPN_W-1:0] idx,
                            input logic [ENTRY_W-1:0] pte);
      send_item(OP_WRITE, VA_W'({$urandom, $urandom}), {page, idx}, pte);
   endtask

   task automatic translate(input logic [VA_W-1:0] va);
      send_item(OP_TRANSLATE, va, EADDR_W'($urandom), {$urandom, $urandom});
   endtask

   // ignored bits of the entry are left random
   function automatic logic [ENTRY_W-1:0] pte_of(input logic [PPN_W-1:0] ppn,
                                                 input logic [3:0] flags);
      logic [ENTRY_W-1:0] e;
      e = {$urandom, $urandom};
      e[PPN_LSB +: PPN_W] = ppn;
      e[BIT_X:BIT_V] = flags;
      return e;
   endfunction

   function automatic logic [VA_W-1:0] make_va(input logic [VPN_W-1:0] vpn2,
                                               input logic [VPN_W-1:0] vpn1,
                                               input logic [VPN_W-1:0] vpn0,
                                               input logic [PAGE_SHIFT-1:0] off);
      return {vpn2, vpn1, vpn0, off};
   endfunction

   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (results_owed != 0);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic configure(input logic [PPN_W-1:0] base, input logic [2:0] root,
                            input logic en);
      logic [CSR_DATA_W-1:0] junk;
      junk = CSR_DATA_W'({$urandom, $urandom});
      settle();
      cfg_base = base;
      cfg_root = root;
      csr_write(CSR_REGION_BASE, base);
      csr_write(CSR_ROOT_PAGE, {junk[CSR_DATA_W-1:ROOT_PAGE_W], root});
      csr_write(CSR_ROOT_ENABLE, {junk[CSR_DATA_W-1:1], en});
      csr_valid <= 1'b0;
   endtask

   // lay down a path from the root to a leaf, sometimes damaged, then walk it
   task automatic map_and_probe();
      logic [VA_W-1:0]    va;
      logic [VA_W-1:0]    page_off_bits;
      logic [ENTRY_W-1:0] pte;
      logic [PPN_W-1:0]   leaf_ppn;
      logic [2:0]         page;
      logic [2:0]         next;
      int                 leaf_lvl;
      int                 damage;
      va       = VA_W'({$urandom, $urandom});
      leaf_lvl = $urandom_range(0, 2);
      page     = cfg_root;
      for (int lvl = 2; lvl >= leaf_lvl; lvl--) begin
         next = 3'($urandom_range(0, PAGES-1));
         if (lvl == leaf_lvl) begin
            leaf_ppn = ($urandom_range(0, 7) == 0) ? '1 : PPN_W'({$urandom, $urandom});
            pte = pte_of(leaf_ppn, {3'($urandom_range(1, 7)), 1'b1});
         end else begin
            pte = pte_of(cfg_base + PPN_W'(next), PTE_PTR);
         end
         damage = $urandom_range(0, 19);
         if (damage == 0)
            pte[BIT_V] = 1'b0;
         else if (damage == 1)
            pte[BIT_X:BIT_R] = '0;
         else if (damage == 2)
            pte[PPN_LSB +: PPN_W] = PPN_W'({$urandom, $urandom});
         write_pte(page, va[PAGE_SHIFT + VPN_W*lvl +: VPN_W], pte);
         page = next;
      end
      page_off_bits = (VA_W'(1) << (PAGE_SHIFT + VPN_W*leaf_lvl)) - VA_W'(1);
      repeat ($urandom_range(1, 3)) begin
         va = (va & ~page_off_bits) | (VA_W'({$urandom, $urandom}) & page_off_bits);
         translate(va);
      end
   endtask

   initial begin
      logic [PPN_W-1:0] dbase;
      logic [PPN_W-1:0] base;
      logic [VA_W-1:0]  va_d;
      int unsigned      target;

      dbase = 44'h123_4567_89ab;
      va_d  = make_va(9'd3, 9'd4, 9'd5, 12'habc);
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // root disabled after reset, even over a leaf
      translate('0);
      write_pte(3'd0, 9'd0, '1);
      translate('0);

      configure(dbase, 3'd5, 1'b1);
      write_pte(3'd5, 9'd3, pte_of(dbase + 44'd2, PTE_PTR));
      write_pte(3'd2, 9'd4, pte_of(dbase + 44'd7, PTE_PTR));
      write_pte(3'd7, 9'd5, pte_of(44'h0ab_cdef_0123, PTE_RV));
      translate(va_d);
      // valid non-leaf at the last level
      write_pte(3'd7, 9'd5, pte_of(44'h0ab_cdef_0123, PTE_PTR));
      translate(va_d);
      write_pte(3'd7, 9'd5, pte_of('1, PTE_XWV));
      translate(make_va(9'd3, 9'd4, 9'd5, 12'hfff));
      // misaligned megapage: sum wraps at the top of the physical space
      write_pte(3'd2, 9'd4, pte_of('1, PTE_XV));
      translate(make_va(9'd3, 9'd4, 9'h1ff, 12'hfff));
      write_pte(3'd5, 9'd3, pte_of('0, PTE_RV));
      translate(make_va(9'd3, 9'h1ff, 9'h1ff, 12'hfff));
      write_pte(3'd5, 9'd3, pte_of(dbase + 44'd2, PTE_RWX_NOV));
      translate(va_d);
      // pointers just outside the table region on either side
      write_pte(3'd5, 9'd3, pte_of(dbase - 44'd1, PTE_PTR));
      translate(va_d);
      write_pte(3'd5, 9'd3, pte_of(dbase + PPN_W'(PAGES), PTE_PTR));
      translate(va_d);
      translate('1);
      send_item(OP_WRITE, '1, '1, '0);

      for (int phase = 0; phase < 8; phase++) begin
         case (phase % 4)
            0:       base = '0;
            1:       base = '1;
            2:       base = PPN_W'({$urandom, $urandom});
            default: base = '1 - PPN_W'($urandom_range(1, PAGES-2));
         endcase
         configure(base,
                   (phase == 0) ? 3'd0 :
                   (phase == 1) ? 3'(PAGES-1) : 3'($urandom_range(0, PAGES-1)),
                   phase != 3);
         target = items_sent + 66;
         while (items_sent < target) begin
            if ($urandom_range(0, 9) < 7)
               map_and_probe();
            else if ($urandom_range(0, 1) == 0)
               translate(VA_W'({$urandom, $urandom}));
            else
               send_item(OP_WRITE, VA_W'({$urandom, $urandom}), EADDR_W'($urandom),
                         {$urandom, $urandom});
         end
      end

      settle();
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== filelist.f =====
hdl/sv39ptw_pkg.sv
hdl/sv39ptw_ram.sv
hdl/sv39ptw_seq.sv
hdl/sv39ptw_dp.sv
hdl/sv39_page_table_walker_top.sv
test/sv39_walk_checker.sv
test/tb_sv39_page_table_walker_top.sv
